// ===== rtl/eight_bit_cpu_instruction_executor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the instruction executor
// Shared property wrappers used at the end of RTL modules.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_INSTRUCTION_EXECUTOR_MACROS_SVH
`define EIGHT_BIT_CPU_INSTRUCTION_EXECUTOR_MACROS_SVH

// assert an implication on every clock, disabled in reset
`define EX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert a property that also holds during reset
`define EX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ebcie_pkg.sv =====
// ----------------------------------------------------------------------------
// ebcie_pkg
// Types and constants shared by the instruction executor.
// ----------------------------------------------------------------------------
package ebcie_pkg;

  localparam logic [7:0]  FlagZ = 8'h80;
  localparam logic [7:0]  FlagN = 8'h40;
  localparam logic [7:0]  FlagH = 8'h20;
  localparam logic [7:0]  FlagC = 8'h10;

  localparam logic [7:0]  ResetA  = 8'h01;
  localparam logic [7:0]  ResetF  = 8'hB0;
  localparam logic [7:0]  ResetB  = 8'h00;
  localparam logic [7:0]  ResetC  = 8'h13;
  localparam logic [7:0]  ResetD  = 8'h00;
  localparam logic [7:0]  ResetE  = 8'hD8;
  localparam logic [7:0]  ResetH  = 8'h01;
  localparam logic [7:0]  ResetL  = 8'h4D;
  localparam logic [15:0] ResetPc = 16'h0100;
  localparam logic [15:0] ResetSp = 16'hFFFE;
  localparam logic [15:0] HighPage = 16'hFF00;
  localparam logic [15:0] RstVector = 16'h0028;

  // input item
  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] code_byte_one;
    logic [7:0] code_byte_two;
    logic [7:0] data_read_first;
    logic [7:0] data_read_second;
  } instr_t;

  // result item
  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        last_result;
    logic [15:0] program_counter;
    logic [15:0] stack_pointer;
    logic [15:0] accumulator_flags;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic        is_halted;
    logic        irq_enabled;
  } result_t;

  // architectural register file
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  f;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] pc;
    logic [15:0] sp;
    logic        halt;
    logic        ime;
  } cpu_state_t;

  // up to two writes of one instruction
  typedef struct packed {
    logic [1:0]  count;
    logic [15:0] addr0;
    logic [7:0]  data0;
    logic [15:0] addr1;
    logic [7:0]  data1;
  } mem_writes_t;

  localparam cpu_state_t ResetState = '{a: ResetA, f: ResetF, b: ResetB, c: ResetC,
    d: ResetD, e: ResetE, h: ResetH, l: ResetL, pc: ResetPc, sp: ResetSp,
    halt: 1'b0, ime: 1'b0};

endpackage

// ===== rtl/ebcie_stream_if.sv =====
// ----------------------------------------------------------------------------
// ebcie_stream_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface ebcie_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/eight_bit_cpu_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// eight_bit_cpu_instruction_executor
// Executes one instruction per input item, emitting its memory writes.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                  Handshake
// instr     in   ebcie_pkg::instr_t       valid/ready, accepted on both high
// result    out  ebcie_pkg::result_t      valid/ready, accepted on both high
//
// An instruction is executed in the cycle it is accepted; its results appear
// from the next cycle. An instruction with no or one write gives one result
// item; one with two writes gives two items in order (the second write is
// parked in a single slot). Reset loads the init register values.
// Input is blocked whenever the result register holds an item that is not
// taken in that cycle, and while the second-write slot holds a parked write.
// ----------------------------------------------------------------------------
`include "eight_bit_cpu_instruction_executor_macros.svh"

module eight_bit_cpu_instruction_executor (
  input  logic    clk_i,
  input  logic    rst_ni,
  ebcie_stream_if.sink   instr_i,
  ebcie_stream_if.source result_o
);
  import ebcie_pkg::*;

  cpu_state_t  st_q, st_d, nx;
  mem_writes_t wr;
  result_t     res_q, res_d, pend_q, pend_d;
  logic        rv_q, rv_d, pv_q, pv_d;
  logic        in_acc, out_acc, out_free;

  ebcie_exec u_exec (
    .instr_i  (instr_i.payload),
    .state_i  (st_q),
    .state_o  (nx),
    .writes_o (wr)
  );

  assign out_acc  = rv_q && result_o.ready;
  assign out_free = !rv_q || (out_acc && !pv_q);
  assign instr_i.ready = out_free;
  assign in_acc   = instr_i.valid && instr_i.ready;

  // result build and queue
  always_comb begin
    result_t base;
    base.write_valid       = 1'b0;
    base.write_address     = 16'd0;
    base.write_data        = 8'd0;
    base.last_result       = 1'b1;
    base.program_counter   = nx.pc;
    base.stack_pointer     = nx.sp;
    base.accumulator_flags = {nx.a, nx.f};
    base.pair_bc           = {nx.b, nx.c};
    base.pair_de           = {nx.d, nx.e};
    base.pair_hl           = {nx.h, nx.l};
    base.is_halted         = nx.halt;
    base.irq_enabled       = nx.ime;
    st_d   = st_q;
    res_d  = res_q;
    rv_d   = rv_q;
    pend_d = pend_q;
    pv_d   = pv_q;
    if (out_acc) begin
      if (pv_q) begin
        res_d = pend_q;
        pv_d  = 1'b0;
      end else begin
        rv_d = 1'b0;
      end
    end
    if (in_acc) begin
      st_d  = nx;
      rv_d  = 1'b1;
      res_d = base;
      if (wr.count != 2'd0) begin
        res_d.write_valid   = 1'b1;
        res_d.write_address = wr.addr0;
        res_d.write_data    = wr.data0;
      end
      if (wr.count == 2'd2) begin
        res_d.last_result    = 1'b0;
        pend_d               = base;
        pend_d.write_valid   = 1'b1;
        pend_d.write_address = wr.addr1;
        pend_d.write_data    = wr.data1;
        pv_d                 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ResetState;
      rv_q <= 1'b0;
      pv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      rv_q <= rv_d;
      pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    pend_q <= pend_d;
  end

  assign result_o.valid   = rv_q;
  assign result_o.payload = res_q;

  `EX_ASSERT(a_pend_needs_res, clk_i, rst_ni, pv_q |-> rv_q, "pending without result")
  `EX_ASSERT(a_pend_not_last, clk_i, rst_ni, pv_q |-> !res_q.last_result, "first write marked last")
  `EX_ASSERT(a_halt_sticky, clk_i, rst_ni, st_q.halt |=> st_q.halt, "halt flag cleared")
  `EX_ASSERT(a_no_accept_full, clk_i, rst_ni, pv_q |-> !instr_i.ready, "accepted while slot full")

endmodule

// ===== rtl/ebcie_exec.sv =====
// ----------------------------------------------------------------------------
// ebcie_exec
// Combinational execution of one instruction: next state and memory writes.
// ----------------------------------------------------------------------------
module ebcie_exec (
  input  ebcie_pkg::instr_t     instr_i,
  input  ebcie_pkg::cpu_state_t state_i,
  output ebcie_pkg::cpu_state_t state_o,
  output ebcie_pkg::mem_writes_t writes_o
);
  import ebcie_pkg::*;

  logic [7:0]  op, b1, b2, r1, r2;
  logic [15:0] imm, ret, pc1, hl, bc, de, rel;
  logic        fz, fc, fn, fh;
  cpu_state_t  s;
  mem_writes_t w;
  // shared 8-bit adder/subtracter
  logic [7:0]  alu_v;
  logic        alu_cy, alu_sub;
  logic [8:0]  alu_sum;
  logic [4:0]  alu_hsum;
  logic [7:0]  alu_flags;
  // inc/dec helpers
  logic [7:0]  idv, idr;
  logic        id_dec;
  logic [7:0]  id_flags;
  // 16-bit add to HL
  logic [15:0] addv;
  logic [16:0] add_s;
  logic [12:0] add_h;
  // rotate
  logic [2:0]  rkind;
  logic [7:0]  rot_r;
  logic        rot_c;
  // daa
  logic [7:0]  corr, daa_a;
  logic        daa_c;
  // cb bit test
  logic [7:0]  bit_v;
  logic [7:0]  a_swap;
  logic        take;

  assign op  = instr_i.opcode;
  assign b1  = instr_i.code_byte_one;
  assign b2  = instr_i.code_byte_two;
  assign r1  = instr_i.data_read_first;
  assign r2  = instr_i.data_read_second;
  assign imm = {b2, b1};
  assign ret = {r2, r1};
  assign pc1 = state_i.pc + 16'd1;
  assign hl  = {state_i.h, state_i.l};
  assign bc  = {state_i.b, state_i.c};
  assign de  = {state_i.d, state_i.e};
  assign fz  = state_i.f[7];
  assign fn  = state_i.f[6];
  assign fh  = state_i.f[5];
  assign fc  = state_i.f[4];
  assign rel = {{8{b1[7]}}, b1};

  // ALU operand selection
  always_comb begin
    alu_v   = b1;
    alu_cy  = 1'b0;
    alu_sub = 1'b0;
    case (op)
      8'h87: alu_v = state_i.a;
      8'hCE: alu_cy = fc;
      8'hBE: begin alu_v = r1; alu_sub = 1'b1; end
      8'hD6, 8'hFE: alu_sub = 1'b1;
      8'hDE: begin alu_sub = 1'b1; alu_cy = fc; end
      default: ;
    endcase
    if (alu_sub) begin
      alu_sum  = {1'b0, state_i.a} - {1'b0, alu_v} - {8'd0, alu_cy};
      alu_hsum = {1'b0, state_i.a[3:0]} - {1'b0, alu_v[3:0]} - {4'd0, alu_cy};
      alu_flags = FlagN | ((alu_sum[7:0] == 8'd0) ? FlagZ : 8'd0)
                | (alu_hsum[4] ? FlagH : 8'd0) | (alu_sum[8] ? FlagC : 8'd0);
    end else begin
      alu_sum  = {1'b0, state_i.a} + {1'b0, alu_v} + {8'd0, alu_cy};
      alu_hsum = {1'b0, state_i.a[3:0]} + {1'b0, alu_v[3:0]} + {4'd0, alu_cy};
      alu_flags = ((alu_sum[7:0] == 8'd0) ? FlagZ : 8'd0)
                | (alu_hsum[4] ? FlagH : 8'd0) | (alu_sum[8] ? FlagC : 8'd0);
    end
  end

  // increment / decrement operand
  always_comb begin
    id_dec = 1'b1;
    case (op)
      8'h04: begin idv = state_i.b; id_dec = 1'b0; end
      8'h0C: begin idv = state_i.c; id_dec = 1'b0; end
      8'h14: begin idv = state_i.d; id_dec = 1'b0; end
      8'h1C: begin idv = state_i.e; id_dec = 1'b0; end
      8'h24: begin idv = state_i.h; id_dec = 1'b0; end
      8'h2C: begin idv = state_i.l; id_dec = 1'b0; end
      8'h05: idv = state_i.b;
      8'h0D: idv = state_i.c;
      8'h15: idv = state_i.d;
      8'h1D: idv = state_i.e;
      8'h25: idv = state_i.h;
      8'h35: idv = r1;
      default: idv = state_i.a;
    endcase
    if (id_dec) begin
      idr = idv - 8'd1;
      id_flags = (state_i.f & FlagC) | FlagN | ((idv[3:0] == 4'd0) ? FlagH : 8'd0)
               | ((idr == 8'd0) ? FlagZ : 8'd0);
    end else begin
      idr = idv + 8'd1;
      id_flags = (state_i.f & FlagC) | ((idr == 8'd0) ? FlagZ : 8'd0)
               | ((idr[3:0] == 4'd0) ? FlagH : 8'd0);
    end
  end

  // 16-bit add into HL
  always_comb begin
    case (op)
      8'h09:   addv = bc;
      8'h19:   addv = de;
      default: addv = hl;
    endcase
    add_s = {1'b0, hl} + {1'b0, addv};
    add_h = {1'b0, hl[11:0]} + {1'b0, addv[11:0]};
  end

  // accumulator rotates and shifts
  always_comb begin
    rkind = (op == 8'hCB) ? b1[5:3] : op[5:3];
    rot_c = (rkind == 3'd0 || rkind == 3'd2 || rkind == 3'd4) ? state_i.a[7] : state_i.a[0];
    case (rkind)
      3'd0:    rot_r = {state_i.a[6:0], state_i.a[7]};
      3'd1:    rot_r = {state_i.a[0], state_i.a[7:1]};
      3'd2:    rot_r = {state_i.a[6:0], fc};
      3'd3:    rot_r = {fc, state_i.a[7:1]};
      3'd4:    rot_r = {state_i.a[6:0], 1'b0};
      3'd5:    rot_r = {state_i.a[7], state_i.a[7:1]};
      default: rot_r = {1'b0, state_i.a[7:1]};
    endcase
  end

  // decimal adjust
  always_comb begin
    corr  = 8'd0;
    daa_c = 1'b0;
    if (fh || (!fn && state_i.a[3:0] > 4'd9)) corr = corr | 8'h06;
    if (fc || (!fn && state_i.a > 8'h99)) begin
      corr  = corr | 8'h60;
      daa_c = 1'b1;
    end
    daa_a = fn ? state_i.a - corr : state_i.a + corr;
  end

  // bit test operand
  always_comb begin
    case (b1[2:0])
      3'd0:    bit_v = state_i.b;
      3'd1:    bit_v = state_i.c;
      3'd2:    bit_v = state_i.d;
      3'd3:    bit_v = state_i.e;
      3'd4:    bit_v = state_i.h;
      3'd5:    bit_v = state_i.l;
      3'd6:    bit_v = r1;
      default: bit_v = state_i.a;
    endcase
  end

  assign a_swap = {state_i.a[3:0], state_i.a[7:4]};

  // main decode
  always_comb begin
    s = state_i;
    s.pc = pc1;
    w = '0;
    take = 1'b0;
    case (op)
      8'h01: begin {s.b, s.c} = imm; s.pc = pc1 + 16'd2; end
      8'h02: begin w.count = 2'd1; w.addr0 = bc; w.data0 = state_i.a; end
      8'h03: {s.b, s.c} = bc + 16'd1;
      8'h04, 8'h05: begin s.b = idr; s.f = id_flags; end
      8'h06: begin s.b = b1; s.pc = pc1 + 16'd1; end
      8'h07, 8'h0F, 8'h17, 8'h1F: begin s.a = rot_r; s.f = rot_c ? FlagC : 8'd0; end
      8'h08: begin
        w.count = 2'd2; w.addr0 = imm; w.data0 = state_i.sp[7:0];
        w.addr1 = imm + 16'd1; w.data1 = state_i.sp[15:8]; s.pc = pc1 + 16'd2;
      end
      8'h09, 8'h19, 8'h29: begin
        {s.h, s.l} = add_s[15:0];
        s.f = (state_i.f & FlagZ) | (add_s[16] ? FlagC : 8'd0) | (add_h[12] ? FlagH : 8'd0);
      end
      8'h0A, 8'h1A, 8'h7E, 8'hF2: s.a = r1;
      8'h0B: {s.b, s.c} = bc - 16'd1;
      8'h0C, 8'h0D: begin s.c = idr; s.f = id_flags; end
      8'h0E: begin s.c = b1; s.pc = pc1 + 16'd1; end
      8'h11: begin {s.d, s.e} = imm; s.pc = pc1 + 16'd2; end
      8'h12: begin w.count = 2'd1; w.addr0 = de; w.data0 = state_i.a; end
      8'h13: {s.d, s.e} = de + 16'd1;
      8'h14, 8'h15: begin s.d = idr; s.f = id_flags; end
      8'h16: begin s.d = b1; s.pc = pc1 + 16'd1; end
      8'h1B: {s.d, s.e} = de - 16'd1;
      8'h1C, 8'h1D: begin s.e = idr; s.f = id_flags; end
      8'h1E: begin s.e = b1; s.pc = pc1 + 16'd1; end
      8'h18, 8'h20, 8'h28: begin
        take = (op == 8'h18) || ((op == 8'h20) ? !fz : fz);
        s.pc = take ? pc1 + 16'd1 + rel : pc1 + 16'd1;
      end
      8'h21: begin {s.h, s.l} = imm; s.pc = pc1 + 16'd2; end
      8'h22: begin
        w.count = 2'd1; w.addr0 = hl; w.data0 = state_i.a; {s.h, s.l} = hl + 16'd1;
      end
      8'h23: {s.h, s.l} = hl + 16'd1;
      8'h24, 8'h25: begin s.h = idr; s.f = id_flags; end
      8'h26: begin s.h = b1; s.pc = pc1 + 16'd1; end
      8'h27: begin
        s.a = daa_a;
        s.f = (state_i.f & FlagN) | ((daa_a == 8'd0) ? FlagZ : 8'd0) | (daa_c ? FlagC : 8'd0);
      end
      8'h2A: begin s.a = r1; {s.h, s.l} = hl + 16'd1; end
      8'h2C: begin s.l = idr; s.f = id_flags; end
      8'h2F: begin s.a = ~state_i.a; s.f = state_i.f | FlagN | FlagH; end
      8'h31: begin s.sp = imm; s.pc = pc1 + 16'd2; end
      8'h32: begin
        w.count = 2'd1; w.addr0 = hl; w.data0 = state_i.a; {s.h, s.l} = hl - 16'd1;
      end
      8'h35: begin w.count = 2'd1; w.addr0 = hl; w.data0 = idr; s.f = id_flags; end
      8'h36: begin w.count = 2'd1; w.addr0 = hl; w.data0 = b1; s.pc = pc1 + 16'd1; end
      8'h37: s.f = (state_i.f & FlagZ) | FlagC;
      8'h3D: begin s.a = idr; s.f = id_flags; end
      8'h3E: begin s.a = b1; s.pc = pc1 + 16'd1; end
      8'h44: s.b = state_i.h;
      8'h47: s.b = state_i.a;
      8'h4F: s.c = state_i.a;
      8'h56: s.d = r1;
      8'h57: s.d = state_i.a;
      8'h5E: s.e = r1;
      8'h5F: s.e = state_i.a;
      8'h67: s.h = state_i.a;
      8'h6F: s.l = state_i.a;
      8'h76: s.halt = 1'b1;
      8'h77: begin w.count = 2'd1; w.addr0 = hl; w.data0 = state_i.a; end
      8'h78: s.a = state_i.b;
      8'h79: s.a = state_i.c;
      8'h7A: s.a = state_i.d;
      8'h7B: s.a = state_i.e;
      8'h7C: s.a = state_i.h;
      8'h7D: s.a = state_i.l;
      8'h87, 8'hC6, 8'hCE: begin
        s.a = alu_sum[7:0]; s.f = alu_flags;
        if (op != 8'h87) s.pc = pc1 + 16'd1;
      end
      8'hD6, 8'hDE: begin s.a = alu_sum[7:0]; s.f = alu_flags; s.pc = pc1 + 16'd1; end
      8'hFE: begin s.f = alu_flags; s.pc = pc1 + 16'd1; end
      8'hBE: s.f = alu_flags;
      8'hA1: begin
        s.a = state_i.a & state_i.c;
        s.f = FlagH | ((s.a == 8'd0) ? FlagZ : 8'd0);
      end
      8'hA7: s.f = FlagH | ((state_i.a == 8'd0) ? FlagZ : 8'd0);
      8'hA9: begin
        s.a = state_i.a ^ state_i.c; s.f = (s.a == 8'd0) ? FlagZ : 8'd0;
      end
      8'hAE: begin s.a = state_i.a ^ r1; s.f = (s.a == 8'd0) ? FlagZ : 8'd0; end
      8'hAF: begin s.a = 8'd0; s.f = FlagZ; end
      8'hB0: begin
        s.a = state_i.a | state_i.b; s.f = (s.a == 8'd0) ? FlagZ : 8'd0;
      end
      8'hB1: begin
        s.a = state_i.a | state_i.c; s.f = (s.a == 8'd0) ? FlagZ : 8'd0;
      end
      8'hB7: s.f = (state_i.a == 8'd0) ? FlagZ : 8'd0;
      8'hE6: begin
        s.a = state_i.a & b1; s.f = FlagH | ((s.a == 8'd0) ? FlagZ : 8'd0);
        s.pc = pc1 + 16'd1;
      end
      8'hC0, 8'hC8, 8'hC9, 8'hD0, 8'hD8: begin
        take = (op == 8'hC9) || (op == 8'hC0 && !fz) || (op == 8'hC8 && fz)
            || (op == 8'hD0 && !fc) || (op == 8'hD8 && fc);
        if (take) begin s.pc = ret; s.sp = state_i.sp + 16'd2; end
      end
      8'hC1: begin {s.b, s.c} = ret; s.sp = state_i.sp + 16'd2; end
      8'hD1: begin {s.d, s.e} = ret; s.sp = state_i.sp + 16'd2; end
      8'hE1: begin {s.h, s.l} = ret; s.sp = state_i.sp + 16'd2; end
      8'hC2, 8'hC3, 8'hCA, 8'hD2, 8'hDA: begin
        take = (op == 8'hC3) || (op == 8'hC2 && !fz) || (op == 8'hCA && fz)
            || (op == 8'hD2 && !fc) || (op == 8'hDA && fc);
        s.pc = take ? imm : pc1 + 16'd2;
      end
      8'hCC, 8'hCD, 8'hD4, 8'hDC: begin
        take = (op == 8'hCD) || (op == 8'hCC && fz) || (op == 8'hD4 && !fc)
            || (op == 8'hDC && fc);
        s.pc = pc1 + 16'd2;
        if (take) begin
          w.count = 2'd2;
          w.addr0 = state_i.sp - 16'd1; w.data0 = s.pc[15:8];
          w.addr1 = state_i.sp - 16'd2; w.data1 = s.pc[7:0];
          s.sp = state_i.sp - 16'd2; s.pc = imm;
        end
      end
      8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
        w.count = 2'd2;
        w.addr0 = state_i.sp - 16'd1; w.addr1 = state_i.sp - 16'd2;
        case (op)
          8'hC5:   {w.data0, w.data1} = bc;
          8'hD5:   {w.data0, w.data1} = de;
          8'hE5:   {w.data0, w.data1} = hl;
          default: {w.data0, w.data1} = {state_i.a, state_i.f};
        endcase
        s.sp = state_i.sp - 16'd2;
      end
      8'hE0: begin
        w.count = 2'd1; w.addr0 = HighPage + {8'd0, b1}; w.data0 = state_i.a;
        s.pc = pc1 + 16'd1;
      end
      8'hE2: begin w.count = 2'd1; w.addr0 = HighPage + {8'd0, state_i.c}; w.data0 = state_i.a; end
      8'hE9: s.pc = hl;
      8'hEA: begin w.count = 2'd1; w.addr0 = imm; w.data0 = state_i.a; s.pc = pc1 + 16'd2; end
      8'hEF: begin
        w.count = 2'd2;
        w.addr0 = state_i.sp - 16'd1; w.data0 = pc1[15:8];
        w.addr1 = state_i.sp - 16'd2; w.data1 = pc1[7:0];
        s.sp = state_i.sp - 16'd2; s.pc = RstVector;
      end
      8'hF0: begin s.a = r1; s.pc = pc1 + 16'd1; end
      8'hF3: s.ime = 1'b0;
      8'hFA: begin s.a = r1; s.pc = pc1 + 16'd2; end
      8'hFB: s.ime = 1'b1;
      8'hCB: begin
        s.pc = pc1 + 16'd1;
        if (b1[7:6] == 2'b01) begin
          s.f = (state_i.f & FlagC) | FlagH | (bit_v[b1[5:3]] ? 8'd0 : FlagZ);
        end else if (b1 == 8'h37) begin
          s.a = a_swap; s.f = (a_swap == 8'd0) ? FlagZ : 8'd0;
        end else if (b1[7:6] == 2'b00 && b1[2:0] == 3'd7) begin
          s.a = rot_r;
          s.f = (rot_c ? FlagC : 8'd0) | ((rot_r == 8'd0) ? FlagZ : 8'd0);
        end else if (b1 == 8'h87) begin
          s.a = state_i.a & 8'hFE;
        end else if (b1 == 8'hC7) begin
          s.a = state_i.a | 8'h01;
        end
      end
      default: ;
    endcase
    if (state_i.halt) begin
      s = state_i;
      w = '0;
    end
  end

  assign state_o  = s;
  assign writes_o = w;

endmodule

// ===== tb/sv/tb_stream_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_if
// The channels use ebcie_stream_if from the RTL; this file documents that
// the testbench relies on that interface and holds its watchdog idle limit.
// ----------------------------------------------------------------------------
package tb_stream_pkg;
  localparam int unsigned IdleLimit = 20000;
endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives instruction items into the executor under random idling and back
// pressure, predicts register state and memory writes per instruction, and
// compares every result item field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ebcie_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  ebcie_stream_if #(.payload_t(instr_t))  instr_ch ();
  ebcie_stream_if #(.payload_t(result_t)) result_ch ();

  eight_bit_cpu_instruction_executor uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .instr_i(instr_ch), .result_o(result_ch)
  );

  // execution model plus queue of expected results
  class exec_scoreboard;
    cpu_state_t st;
    result_t pending[$];
    int errors;

    function new();
      st = ResetState;
      errors = 0;
    endfunction

    function void set_flags_inc(logic [7:0] v);
      st.f = (st.f & FlagC) | (v == 0 ? FlagZ : 8'h0) | (v[3:0] == 0 ? FlagH : 8'h0);
    endfunction

    function logic [7:0] do_dec(logic [7:0] v);
      logic [7:0] r;
      r = v - 8'd1;
      st.f = (st.f & FlagC) | FlagN | (v[3:0] == 0 ? FlagH : 8'h0) | (r == 0 ? FlagZ : 8'h0);
      return r;
    endfunction

    function void do_add_hl(logic [15:0] v);
      logic [16:0] s;
      logic [12:0] hs;
      s = {1'b0, st.h, st.l} + v;
      hs = {1'b0, st.h[3:0], st.l} + {1'b0, v[11:0]};
      st.f = (st.f & FlagZ) | (s[16] ? FlagC : 8'h0) | (hs[12] ? FlagH : 8'h0);
      {st.h, st.l} = s[15:0];
    endfunction

    function void do_add8(logic [7:0] v, logic cy);
      logic [8:0] s;
      logic [4:0] hs;
      s = st.a + v + cy;
      hs = st.a[3:0] + v[3:0] + cy;
      st.f = (s[7:0] == 0 ? FlagZ : 8'h0) | (s[8] ? FlagC : 8'h0) | (hs[4] ? FlagH : 8'h0);
      st.a = s[7:0];
    endfunction

    function logic [7:0] do_sub8(logic [7:0] v, logic cy);
      logic [7:0] r;
      r = st.a - v - cy;
      st.f = FlagN | (r == 0 ? FlagZ : 8'h0)
           | ({1'b0, st.a[3:0]} < ({1'b0, v[3:0]} + cy) ? FlagH : 8'h0)
           | ({1'b0, st.a} < ({1'b0, v} + cy) ? FlagC : 8'h0);
      return r;
    endfunction

    function void logic_fl(logic [7:0] hf);
      st.f = (st.a == 0 ? FlagZ : 8'h0) | hf;
    endfunction

    function void do_rot(logic [2:0] kind);
      logic [7:0] a;
      logic oc, co;
      a = st.a;
      oc = st.f[4];
      co = (kind == 0 || kind == 2 || kind == 4) ? a[7] : a[0];
      case (kind)
        3'd0: st.a = {a[6:0], co};
        3'd1: st.a = {co, a[7:1]};
        3'd2: st.a = {a[6:0], oc};
        3'd3: st.a = {oc, a[7:1]};
        3'd4: st.a = {a[6:0], 1'b0};
        3'd5: st.a = {a[7], a[7:1]};
        default: st.a = {1'b0, a[7:1]};
      endcase
      st.f = co ? FlagC : 8'h0;
    endfunction

    function logic [7:0] pick_reg(logic [2:0] idx, logic [7:0] mem);
      case (idx)
        3'd0: return st.b;
        3'd1: return st.c;
        3'd2: return st.d;
        3'd3: return st.e;
        3'd4: return st.h;
        3'd5: return st.l;
        3'd6: return mem;
        default: return st.a;
      endcase
    endfunction

    // execute one instruction and queue the results it causes
    function void note_instr(instr_t it);
      logic [15:0] imm, ret, pc, hl, wa[2];
      logic [7:0] wd[2], b1, r1, v;
      logic fz, fc, take, nf, setc;
      int nw, n;
      result_t r;
      b1 = it.code_byte_one;
      r1 = it.data_read_first;
      imm = {it.code_byte_two, b1};
      ret = {it.data_read_second, r1};
      fz = st.f[7];
      fc = st.f[4];
      nw = 0;
      if (!st.halt) begin
        pc = st.pc + 16'd1;
        hl = {st.h, st.l};
        case (it.opcode)
          8'h01: begin {st.b, st.c} = imm; pc += 2; end
          8'h02: begin wa[nw] = {st.b, st.c}; wd[nw] = st.a; nw++; end
          8'h03: {st.b, st.c} = {st.b, st.c} + 16'd1;
          8'h04: begin st.b++; set_flags_inc(st.b); end
          8'h05: st.b = do_dec(st.b);
          8'h06: begin st.b = b1; pc += 1; end
          8'h07: do_rot(0);
          8'h08: begin
            wa[0] = imm; wd[0] = st.sp[7:0];
            wa[1] = imm + 16'd1; wd[1] = st.sp[15:8]; nw = 2; pc += 2;
          end
          8'h09: do_add_hl({st.b, st.c});
          8'h0A, 8'h1A, 8'h7E, 8'hF2: st.a = r1;
          8'h0B: {st.b, st.c} = {st.b, st.c} - 16'd1;
          8'h0C: begin st.c++; set_flags_inc(st.c); end
          8'h0D: st.c = do_dec(st.c);
          8'h0E: begin st.c = b1; pc += 1; end
          8'h0F: do_rot(1);
          8'h11: begin {st.d, st.e} = imm; pc += 2; end
          8'h12: begin wa[0] = {st.d, st.e}; wd[0] = st.a; nw = 1; end
          8'h13: {st.d, st.e} = {st.d, st.e} + 16'd1;
          8'h14: begin st.d++; set_flags_inc(st.d); end
          8'h15: st.d = do_dec(st.d);
          8'h16: begin st.d = b1; pc += 1; end
          8'h17: do_rot(2);
          8'h19: do_add_hl({st.d, st.e});
          8'h1B: {st.d, st.e} = {st.d, st.e} - 16'd1;
          8'h1C: begin st.e++; set_flags_inc(st.e); end
          8'h1D: st.e = do_dec(st.e);
          8'h1E: begin st.e = b1; pc += 1; end
          8'h1F: do_rot(3);
          8'h18, 8'h20, 8'h28: begin
            take = it.opcode == 8'h18 || (it.opcode == 8'h20 ? !fz : fz);
            pc += 1;
            if (take) pc = pc + {{8{b1[7]}}, b1};
          end
          8'h21: begin {st.h, st.l} = imm; pc += 2; end
          8'h22: begin wa[0] = hl; wd[0] = st.a; nw = 1; {st.h, st.l} = hl + 16'd1; end
          8'h23: {st.h, st.l} = hl + 16'd1;
          8'h24: begin st.h++; set_flags_inc(st.h); end
          8'h25: st.h = do_dec(st.h);
          8'h26: begin st.h = b1; pc += 1; end
          8'h27: begin
            logic [7:0] corr;
            corr = 0; nf = st.f[6]; setc = 0;
            if (st.f[5] || (!nf && st.a[3:0] > 9)) corr |= 8'h06;
            if (fc || (!nf && st.a > 8'h99)) begin corr |= 8'h60; setc = 1; end
            st.a = nf ? st.a - corr : st.a + corr;
            st.f = (st.f & FlagN) | (st.a == 0 ? FlagZ : 8'h0) | (setc ? FlagC : 8'h0);
          end
          8'h29: do_add_hl(hl);
          8'h2A: begin st.a = r1; {st.h, st.l} = hl + 16'd1; end
          8'h2C: begin st.l++; set_flags_inc(st.l); end
          8'h2F: begin st.a = ~st.a; st.f = st.f | FlagN | FlagH; end
          8'h31: begin st.sp = imm; pc += 2; end
          8'h32: begin wa[0] = hl; wd[0] = st.a; nw = 1; {st.h, st.l} = hl - 16'd1; end
          8'h35: begin v = do_dec(r1); wa[0] = hl; wd[0] = v; nw = 1; end
          8'h36: begin wa[0] = hl; wd[0] = b1; nw = 1; pc += 1; end
          8'h37: st.f = (st.f & FlagZ) | FlagC;
          8'h3D: st.a = do_dec(st.a);
          8'h3E: begin st.a = b1; pc += 1; end
          8'h44: st.b = st.h;
          8'h47: st.b = st.a;
          8'h4F: st.c = st.a;
          8'h56: st.d = r1;
          8'h57: st.d = st.a;
          8'h5E: st.e = r1;
          8'h5F: st.e = st.a;
          8'h67: st.h = st.a;
          8'h6F: st.l = st.a;
          8'h76: st.halt = 1'b1;
          8'h77: begin wa[0] = hl; wd[0] = st.a; nw = 1; end
          8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D: st.a = pick_reg(it.opcode[2:0], 8'h0);
          8'h87: do_add8(st.a, 1'b0);
          8'hA1: begin st.a &= st.c; logic_fl(FlagH); end
          8'hA7: logic_fl(FlagH);
          8'hA9: begin st.a ^= st.c; logic_fl(8'h0); end
          8'hAE: begin st.a ^= r1; logic_fl(8'h0); end
          8'hAF: begin st.a = 0; logic_fl(8'h0); end
          8'hB0: begin st.a |= st.b; logic_fl(8'h0); end
          8'hB1: begin st.a |= st.c; logic_fl(8'h0); end
          8'hB7: logic_fl(8'h0);
          8'hBE: v = do_sub8(r1, 1'b0);
          8'hC0, 8'hC8, 8'hC9, 8'hD0, 8'hD8: begin
            take = it.opcode == 8'hC9 || (it.opcode == 8'hC0 && !fz)
                || (it.opcode == 8'hC8 && fz) || (it.opcode == 8'hD0 && !fc)
                || (it.opcode == 8'hD8 && fc);
            if (take) begin pc = ret; st.sp += 2; end
          end
          8'hC1: begin {st.b, st.c} = ret; st.sp += 2; end
          8'hD1: begin {st.d, st.e} = ret; st.sp += 2; end
          8'hE1: begin {st.h, st.l} = ret; st.sp += 2; end
          8'hC2, 8'hC3, 8'hCA, 8'hD2, 8'hDA: begin
            take = it.opcode == 8'hC3 || (it.opcode == 8'hC2 && !fz)
                || (it.opcode == 8'hCA && fz) || (it.opcode == 8'hD2 && !fc)
                || (it.opcode == 8'hDA && fc);
            pc = take ? imm : pc + 16'd2;
          end
          8'hCC, 8'hCD, 8'hD4, 8'hDC, 8'hEF, 8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
            logic [15:0] pv;
            take = 1;
            pv = 0;
            case (it.opcode)
              8'hCC: take = fz;
              8'hD4: take = !fc;
              8'hDC: take = fc;
              default: ;
            endcase
            if (it.opcode inside {8'hCC, 8'hCD, 8'hD4, 8'hDC}) pc += 2;
            case (it.opcode)
              8'hC5: pv = {st.b, st.c};
              8'hD5: pv = {st.d, st.e};
              8'hE5: pv = hl;
              8'hF5: pv = {st.a, st.f};
              default: pv = pc;
            endcase
            if (take) begin
              wa[0] = st.sp - 16'd1; wd[0] = pv[15:8];
              wa[1] = st.sp - 16'd2; wd[1] = pv[7:0];
              nw = 2; st.sp -= 2;
              if (it.opcode == 8'hEF) pc = RstVector;
              else if (it.opcode inside {8'hCC, 8'hCD, 8'hD4, 8'hDC}) pc = imm;
            end
          end
          8'hC6: begin do_add8(b1, 1'b0); pc += 1; end
          8'hCE: begin do_add8(b1, fc); pc += 1; end
          8'hD6: begin st.a = do_sub8(b1, 1'b0); pc += 1; end
          8'hDE: begin st.a = do_sub8(b1, fc); pc += 1; end
          8'hFE: begin v = do_sub8(b1, 1'b0); pc += 1; end
          8'hE6: begin st.a &= b1; logic_fl(FlagH); pc += 1; end
          8'hE0: begin wa[0] = HighPage + b1; wd[0] = st.a; nw = 1; pc += 1; end
          8'hE2: begin wa[0] = HighPage + st.c; wd[0] = st.a; nw = 1; end
          8'hE9: pc = hl;
          8'hEA: begin wa[0] = imm; wd[0] = st.a; nw = 1; pc += 2; end
          8'hF0: begin st.a = r1; pc += 1; end
          8'hF3: st.ime = 1'b0;
          8'hFA: begin st.a = r1; pc += 2; end
          8'hFB: st.ime = 1'b1;
          8'hCB: begin
            pc += 1;
            if (b1 >= 8'h40 && b1 <= 8'h7F) begin
              v = pick_reg(b1[2:0], r1);
              st.f = (st.f & FlagC) | FlagH | (v[b1[5:3]] ? 8'h0 : FlagZ);
            end else if (b1 == 8'h37) begin
              st.a = {st.a[3:0], st.a[7:4]};
              logic_fl(8'h0);
            end else if (b1 < 8'h40 && b1[2:0] == 3'd7) begin
              do_rot(b1[5:3]);
              if (st.a == 0) st.f |= FlagZ;
            end else if (b1 == 8'h87) st.a &= 8'hFE;
            else if (b1 == 8'hC7) st.a |= 8'h01;
          end
          default: ;
        endcase
        st.pc = pc;
      end
      n = nw > 0 ? nw : 1;
      for (int k = 0; k < n; k++) begin
        r.write_valid = k < nw;
        r.write_address = k < nw ? wa[k] : 16'h0;
        r.write_data = k < nw ? wd[k] : 8'h0;
        r.last_result = k == n - 1;
        r.program_counter = st.pc;
        r.stack_pointer = st.sp;
        r.accumulator_flags = {st.a, st.f};
        r.pair_bc = {st.b, st.c};
        r.pair_de = {st.d, st.e};
        r.pair_hl = {st.h, st.l};
        r.is_halted = st.halt;
        r.irq_enabled = st.ime;
        pending.push_back(r);
      end
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("unexpected result item %0h", got);
        return;
      end
      e = pending.pop_front();
      if (got.write_valid !== e.write_valid) report("write_valid", got.write_valid, e.write_valid);
      if (got.write_address !== e.write_address)
        report("write_address", got.write_address, e.write_address);
      if (got.write_data !== e.write_data) report("write_data", got.write_data, e.write_data);
      if (got.last_result !== e.last_result) report("last_result", got.last_result, e.last_result);
      if (got.program_counter !== e.program_counter)
        report("program_counter", got.program_counter, e.program_counter);
      if (got.stack_pointer !== e.stack_pointer)
        report("stack_pointer", got.stack_pointer, e.stack_pointer);
      if (got.accumulator_flags !== e.accumulator_flags)
        report("accumulator_flags", got.accumulator_flags, e.accumulator_flags);
      if (got.pair_bc !== e.pair_bc) report("pair_bc", got.pair_bc, e.pair_bc);
      if (got.pair_de !== e.pair_de) report("pair_de", got.pair_de, e.pair_de);
      if (got.pair_hl !== e.pair_hl) report("pair_hl", got.pair_hl, e.pair_hl);
      if (got.is_halted !== e.is_halted) report("is_halted", got.is_halted, e.is_halted);
      if (got.irq_enabled !== e.irq_enabled) report("irq_enabled", got.irq_enabled, e.irq_enabled);
    endfunction
  endclass

  exec_scoreboard sb = new();
  int send_idle_pct = 32;
  int recv_idle_pct = 46;
  bit recv_hold = 1'b0;
  int quiet_cycles = 0;

  // implemented opcodes, used to bias random stimulus
  logic [7:0] known_ops[$] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
    8'h19, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
    8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2C, 8'h2F, 8'h31, 8'h32, 8'h35, 8'h36,
    8'h37, 8'h3D, 8'h3E, 8'h44, 8'h47, 8'h4F, 8'h56, 8'h57, 8'h5E, 8'h5F, 8'h67, 8'h6F,
    8'h77, 8'h78, 8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h7F, 8'h87, 8'hA1, 8'hA7,
    8'hA9, 8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hB7, 8'hBE, 8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC5,
    8'hC6, 8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hD0, 8'hD1, 8'hD2, 8'hD4,
    8'hD5, 8'hD6, 8'hD8, 8'hDA, 8'hDC, 8'hDE, 8'hE0, 8'hE1, 8'hE2, 8'hE5, 8'hE6, 8'hE9,
    8'hEA, 8'hEF, 8'hF0, 8'hF2, 8'hF3, 8'hF5, 8'hFA, 8'hFB, 8'hFE};

  initial begin
    instr_ch.valid = 1'b0;
    instr_ch.payload = '0;
    result_ch.ready = 1'b0;
  end

  // result side: random stall, optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) sb.check_result(result_ch.payload);
      result_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > tb_stream_pkg::IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one instruction until it is accepted; valid drops only while idling
  task automatic send_instr(instr_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.payload <= it;
    do @(posedge clk_i); while (!instr_ch.ready);
    sb.note_instr(it);
  endtask

  task automatic send_op(logic [7:0] op, logic [7:0] b1);
    instr_t it;
    it.opcode = op;
    it.code_byte_one = b1;
    it.code_byte_two = 8'($urandom);
    it.data_read_first = 8'($urandom);
    it.data_read_second = 8'($urandom);
    send_instr(it);
  endtask

  task automatic send_random(int count);
    instr_t it;
    repeat (count) begin
      it = {8'($urandom), $urandom};
      if ($urandom_range(9) < 8) it.opcode = known_ops[$urandom_range(known_ops.size() - 1)];
      if (it.opcode == 8'h76 && $urandom_range(3) != 0) it.opcode = 8'h00;
      send_instr(it);
    end
  endtask

  task automatic drain();
    instr_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, pushes, CB forms, unknown codes
    send_op(8'h3E, 8'h00);
    send_op(8'h3D, 8'h00);
    send_op(8'h27, 8'h00);
    send_op(8'hC6, 8'hFF);
    send_op(8'hCE, 8'hFF);
    send_op(8'hDE, 8'h80);
    send_op(8'h31, 8'h00);
    send_op(8'hC5, 8'h00);
    send_op(8'hCD, 8'hFF);
    send_op(8'h08, 8'hFF);
    send_op(8'h18, 8'h80);
    send_op(8'h18, 8'h7F);
    send_op(8'hCB, 8'h7E);
    send_op(8'hCB, 8'h37);
    send_op(8'hCB, 8'h3F);
    send_op(8'hCB, 8'h87);
    send_op(8'hCB, 8'hC7);
    send_op(8'hCB, 8'hFF);
    send_op(8'hD3, 8'h00);
    send_op(8'hFF, 8'hFF);
    send_op(8'hFB, 8'h00);
    send_op(8'hEF, 8'h00);
    send_op(8'hC9, 8'hFF);
    // full drain once between phases
    drain();

    // receiver holds off while sender keeps pushing
    recv_hold = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      send_random(20);
    join
    drain();

    send_random(330);
    send_idle_pct = 46;
    recv_idle_pct = 32;
    send_random(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(300);
    // halted state last
    send_op(8'h76, 8'h00);
    send_random(10);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
